@@ sv/ugm_pkg.sv @@
package ugm_pkg;

    localparam int CP_W   = 21;
    localparam int SLOT_W = 7;
    localparam int CNT_W  = 3;

    localparam logic [7:0] BOX_GLYPH  = 8'h7f;
    localparam logic [7:0] DASH_GLYPH = 8'h2d;

    // Command codes on the input tuser bit
    localparam logic CMD_TEXT = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    // Search token that walks the row of table cells
    typedef struct packed {
        logic              valid;
        logic              found;
        logic [SLOT_W-1:0] idx;
        logic [CP_W-1:0]   key;
    } ugm_token_t;

    // Sequence length announced by a lead byte, 0 when it is no lead
    function automatic logic [2:0] lead_len(input logic [7:0] b);
        logic [2:0] len;
        len = 3'd0;
        if (b[7:5] == 3'b110)
            len = 3'd2;
        else if (b[7:4] == 4'b1110)
            len = 3'd3;
        else if (b[7:3] == 5'b11110)
            len = 3'd4;
        return len;
    endfunction

endpackage

@@ sv/ugm_cell.sv @@
module ugm_cell
    import ugm_pkg::*;
#(
    parameter int INDEX = 0
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  logic [CP_W-1:0] wr_cp,
    input  ugm_token_t      tok_in,
    output ugm_token_t      tok_out
);

    logic [CP_W-1:0] entry_reg;
    logic            tok_valid_reg;
    ugm_token_t      tok_reg;
    ugm_token_t      tok_next;

    // Table slot held by this cell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            entry_reg <= '0;
        else if (wr_en)
            entry_reg <= wr_cp;
    end

    // First matching cell marks the token
    always_comb
    begin
        tok_next = tok_in;
        if (tok_in.valid && !tok_in.found && entry_reg == tok_in.key)
        begin
            tok_next.found = 1'b1;
            tok_next.idx   = SLOT_W'(INDEX);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tok_valid_reg <= 1'b0;
        else
            tok_valid_reg <= tok_next.valid;
    end

    always_ff @(posedge clk)
    begin
        tok_reg <= tok_next;
    end

    always_comb
    begin
        tok_out       = tok_reg;
        tok_out.valid = tok_valid_reg;
    end

endmodule

@@ sv/utf8_to_glyph_mapper.sv @@
// UTF-8 text to 8-bit font glyph mapper.
// Input stream: one item per accepted beat. tuser[0] = 0 carries a text byte
// in tdata[7:0] with tlast marking the end of text; tuser[0] = 1 loads table
// slot tdata[13:8] with code point tdata[34:14] and gives no result.
// Output stream: one glyph per beat in tdata[7:0]; tlast marks the final
// glyph caused by an input item, tuser[0] marks the final glyph of the text.
// A text byte gives 0 to 4 glyphs. Config port: cfg_data[0] sets upper case
// folding, always ready, write only while idle.
// Timing: one item at a time. A byte is decoded when accepted, a completed
// character then goes through the fixed mappings, then its glyphs are issued
// one by one; table loads and held bytes finish on acceptance. A code point
// outside the fixed mappings walks the TABLE_DEPTH cells, one cell per cycle.
// Reset clears held bytes, the table and the mode. A stalled receiver holds
// the output register; the next input is taken once the last glyph of the
// previous item sits in that register.
module utf8_to_glyph_mapper
    import ugm_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // text_byte, entry_index, entry_codepoint
    input  logic        s_axis_tlast,
    input  logic [0:0]  s_axis_tuser,   // command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // glyph_code
    output logic        m_axis_tlast,
    output logic [0:0]  m_axis_tuser,   // text_done
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_MAP    = 4'b0010,
        S_SEARCH = 4'b0100,
        S_EMIT   = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic            upper_reg;
    logic [7:0]      pend_reg [3];
    logic [1:0]      pc_reg, pc_next;
    logic [2:0]      sl_reg, sl_next;
    logic [CNT_W-1:0] pre_reg, rem_reg;
    logic            main_reg, end_reg;
    logic [CP_W-1:0] cp_reg;
    logic [7:0]      main_glyph_reg;
    logic            out_valid_reg;
    logic [7:0]      out_glyph_reg;
    logic            out_last_reg, out_done_reg;

    logic            accept, is_load, is_text;
    logic [7:0]      b;
    logic [5:0]      slot;
    logic [CP_W-1:0] load_cp;
    logic            is_cont;
    logic [2:0]      len;
    logic [CP_W-1:0] comp_cp;
    logic            comp_ok;
    logic [CNT_W-1:0] d_pre, d_post;
    logic            d_main;
    logic [CP_W-1:0] d_cp;
    logic            d_store;
    logic [1:0]      d_widx;

    assign accept  = s_axis_tvalid && s_axis_tready;
    assign is_load = s_axis_tuser[0] == CMD_LOAD;
    assign is_text = s_axis_tuser[0] == CMD_TEXT;
    assign b       = s_axis_tdata[7:0];
    assign slot    = s_axis_tdata[13:8];
    assign load_cp = s_axis_tdata[34:14];
    assign is_cont = b[7:6] == 2'b10;
    assign len     = lead_len(b);

    assign s_axis_tready = state_reg == S_IDLE;
    assign cfg_ready     = 1'b1;

    // Mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            upper_reg <= 1'b0;
        else if (cfg_valid)
            upper_reg <= cfg_data[0];
    end

    // Code point of a completed sequence
    always_comb
    begin
        comp_cp = '0;
        comp_ok = 1'b0;
        unique case (sl_reg)
            3'd2:
            begin
                comp_cp = CP_W'({pend_reg[0][4:0], b[5:0]});
                comp_ok = comp_cp >= CP_W'(32'h80);
            end
            3'd3:
            begin
                comp_cp = CP_W'({pend_reg[0][3:0], pend_reg[1][5:0], b[5:0]});
                comp_ok = comp_cp >= CP_W'(32'h800);
            end
            default:
            begin
                comp_cp = {pend_reg[0][2:0], pend_reg[1][5:0], pend_reg[2][5:0], b[5:0]};
                comp_ok = comp_cp >= CP_W'(32'h10000) && comp_cp <= CP_W'(32'h10ffff);
            end
        endcase
    end

    // Byte decode: boxes before, one mapped character, boxes after
    always_comb
    begin
        d_pre   = '0;
        d_post  = '0;
        d_main  = 1'b0;
        d_cp    = CP_W'(b);
        d_store = 1'b0;
        d_widx  = pc_reg;
        pc_next = pc_reg;
        sl_next = sl_reg;
        if (pc_reg == 2'd0 || !is_cont)
        begin
            d_pre   = CNT_W'(pc_reg);
            pc_next = 2'd0;
            sl_next = 3'd0;
            if (!b[7])
                d_main = 1'b1;
            else if (len != 3'd0)
            begin
                // new lead byte always lands in the first slot
                pc_next = 2'd1;
                sl_next = len;
                d_store = 1'b1;
                d_widx  = 2'd0;
            end
            else
                d_pre = d_pre + CNT_W'(1);
        end
        else if ({1'b0, pc_reg} + 3'd1 >= sl_reg)
        begin
            d_main  = 1'b1;
            d_cp    = comp_cp;
            d_post  = comp_ok ? '0 : CNT_W'(sl_reg - 3'd1);
            pc_next = 2'd0;
            sl_next = 3'd0;
        end
        else
        begin
            d_store = 1'b1;
            pc_next = pc_reg + 2'd1;
        end
        if (s_axis_tlast)
        begin
            d_post  = d_post + CNT_W'(pc_next);
            pc_next = 2'd0;
            sl_next = 3'd0;
        end
    end

    // Held sequence state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= 2'd0;
            sl_reg <= 3'd0;
            for (int i = 0; i < 3; i++)
                pend_reg[i] <= 8'h00;
        end
        else if (accept && is_text)
        begin
            pc_reg <= pc_next;
            sl_reg <= sl_next;
            if (d_store)
                pend_reg[d_widx] <= b;
        end
    end

    // Fixed mappings after optional folding
    logic [CP_W-1:0] fold_cp;
    logic            fast_hit;
    logic [7:0]      fast_glyph;

    always_comb
    begin
        fold_cp = cp_reg;
        if (upper_reg)
        begin
            if ((cp_reg >= CP_W'(32'h61) && cp_reg <= CP_W'(32'h7a))
                || (cp_reg >= CP_W'(32'h430) && cp_reg <= CP_W'(32'h44f)))
                fold_cp = cp_reg - CP_W'(32'h20);
            else if (cp_reg == CP_W'(32'h451))
                fold_cp = CP_W'(32'h401);
        end
        fast_hit   = 1'b1;
        fast_glyph = BOX_GLYPH;
        priority if ((fold_cp >= CP_W'(32'h2010) && fold_cp <= CP_W'(32'h2015))
                     || fold_cp == CP_W'(32'h2212))
            fast_glyph = DASH_GLYPH;
        else if (fold_cp < CP_W'(32'h7f))
            fast_glyph = fold_cp[7:0];
        else if (fold_cp == CP_W'(32'h401))
            fast_glyph = 8'ha8;
        else if (fold_cp == CP_W'(32'h451))
            fast_glyph = 8'hb8;
        else if (fold_cp >= CP_W'(32'h410) && fold_cp <= CP_W'(32'h44f))
            fast_glyph = 8'hc0 + (fold_cp[7:0] - 8'h10);
        else
            fast_hit = 1'b0;
    end

    // Row of table cells
    ugm_token_t tok [TABLE_DEPTH+1];

    always_comb
    begin
        tok[0].valid = state_reg == S_MAP && !fast_hit;
        tok[0].found = 1'b0;
        tok[0].idx   = '0;
        tok[0].key   = fold_cp;
    end

    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        ugm_cell #(.INDEX(i)) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .wr_en   (accept && is_load && ({1'b0, slot} == SLOT_W'(i))),
            .wr_cp   (load_cp),
            .tok_in  (tok[i]),
            .tok_out (tok[i+1])
        );
    end

    // Sequencer
    logic emit;
    assign emit = state_reg == S_EMIT && (!out_valid_reg || m_axis_tready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (accept && is_text)
                begin
                    if (d_main)
                        state_next = S_MAP;
                    else if (d_pre + d_post != '0)
                        state_next = S_EMIT;
                end
            S_MAP:
                state_next = fast_hit ? S_EMIT : S_SEARCH;
            S_SEARCH:
                if (tok[TABLE_DEPTH].valid)
                    state_next = S_EMIT;
            S_EMIT:
                if (emit && rem_reg == CNT_W'(1))
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pre_reg   <= '0;
            rem_reg   <= '0;
            main_reg  <= 1'b0;
            end_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept && is_text)
            begin
                pre_reg  <= d_pre;
                main_reg <= d_main;
                end_reg  <= s_axis_tlast;
                rem_reg  <= d_pre + d_post + CNT_W'(d_main);
            end
            else if (emit)
            begin
                rem_reg <= rem_reg - CNT_W'(1);
                if (pre_reg != '0)
                    pre_reg <= pre_reg - CNT_W'(1);
                else if (main_reg)
                    main_reg <= 1'b0;
            end
        end
    end

    // Character payload
    always_ff @(posedge clk)
    begin
        if (accept && is_text)
            cp_reg <= d_cp;
        if (state_reg == S_MAP && fast_hit)
            main_glyph_reg <= fast_glyph;
        else if (state_reg == S_SEARCH && tok[TABLE_DEPTH].valid)
            main_glyph_reg <= tok[TABLE_DEPTH].found ? {1'b1, tok[TABLE_DEPTH].idx}
                                                     : BOX_GLYPH;
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_glyph_reg <= (pre_reg == '0 && main_reg) ? main_glyph_reg : BOX_GLYPH;
            out_last_reg  <= rem_reg == CNT_W'(1);
            out_done_reg  <= rem_reg == CNT_W'(1) && end_reg;
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_glyph_reg;
    assign m_axis_tlast    = out_last_reg;
    assign m_axis_tuser[0] = out_done_reg;

endmodule

@@ sv/ugm_checker.sv @@
module ugm_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [39:0] s_axis_tdata,
    input logic        s_axis_tlast,
    input logic [0:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic        m_axis_tlast,
    input logic [0:0]  m_axis_tuser
);

    // Stalled output item holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output item changed under stall");

    // End of text only on the final glyph of an item
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast)
        else $error("text_done without last_of_run");

    // A table load produces no output item
    a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser[0] && !m_axis_tvalid
        |=> !m_axis_tvalid)
        else $error("table load produced an item");

    // No input taken while a multi glyph run is still being issued
    a_run_gap: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |-> !s_axis_tready)
        else $error("input taken inside a run");

endmodule

bind utf8_to_glyph_mapper ugm_checker u_ugm_checker (.*);
